/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/skvm_pkg.sv */
// types, constants and helpers for the sorted key-value map
`timescale 1ns / 1ps

package skvm_pkg;

    localparam int CAPACITY = 64;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = 7;

    localparam logic [1:0] ACT_PUT    = 2'd0;
    localparam logic [1:0] ACT_GET    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;
    localparam logic signed [KEY_W-1:0] NO_VALUE = '1;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [KEY_W-1:0] store_value;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic signed [KEY_W-1:0] read_value;
        logic                    full_error;
        logic [ENTRY_W-1:0]      entry_count;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

    function automatic logic [ENTRY_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
        if (int'(c) > int'(ENTRY_MAX))
            return ENTRY_MAX;
        else
            return ENTRY_W'(c);
    endfunction

endpackage

/* rtl/skvm_ctrl.sv */
// request sequencer: accept, evaluate, hand result to the output register
`timescale 1ns / 1ps

module skvm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output skvm_pkg::dp_cmd_t cmd
);
    import skvm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = req_valid;
                if (req_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.commit = !rsp_valid_reg || !rsp_stall;
                if (cmd.commit)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/skvm_dp.sv */
// sorted slot row with per-slot compare, shift insert/delete and result register
`timescale 1ns / 1ps

module skvm_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  skvm_pkg::dp_cmd_t cmd,
    input  skvm_pkg::req_t    req,
    output skvm_pkg::rsp_t    rsp
);
    import skvm_pkg::*;

    logic signed [KEY_W-1:0] key_reg [CAPACITY];
    logic signed [KEY_W-1:0] val_reg [CAPACITY];
    logic [CAPACITY-1:0]     valid_reg, valid_next;
    logic [CAPACITY-1:0]     lt_reg, eq_reg, lt_cmp, eq_cmp;
    logic [COUNT_W-1:0]      count_reg, count_next;
    req_t                    req_reg;
    rsp_t                    rsp_reg;

    logic                    is_put, is_get, is_remove;
    logic                    hit, full;
    logic                    do_update, do_insert, do_remove;
    logic signed [KEY_W-1:0] hit_value;

    // compare every slot against the incoming key
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cmp
        assign lt_cmp[i] = valid_reg[i] && ($signed(key_reg[i]) < $signed(req.lookup_key));
        assign eq_cmp[i] = valid_reg[i] && (key_reg[i] == req.lookup_key);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            lt_reg  <= lt_cmp;
            eq_reg  <= eq_cmp;
        end
    end

    always_comb
    begin
        is_put    = 1'b0;
        is_get    = 1'b0;
        is_remove = 1'b0;
        unique case (req_reg.action)
            ACT_PUT:    is_put    = 1'b1;
            ACT_GET:    is_get    = 1'b1;
            ACT_REMOVE: is_remove = 1'b1;
            default:    ;
        endcase
    end

    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
            hit_value = hit_value | (eq_reg[i] ? val_reg[i] : '0);
    end

    assign hit       = |eq_reg;
    assign full      = (count_reg == COUNT_W'(CAPACITY));
    assign do_update = is_put && hit;
    assign do_insert = is_put && !hit && !full;
    assign do_remove = is_remove && hit;

    // slot row update
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_slot
        logic                    ins_here;
        logic signed [KEY_W-1:0] prev_key, prev_val, next_key, next_val;

        if (i == 0)
        begin : g_first
            assign ins_here = 1'b1;
            assign prev_key = key_reg[i];
            assign prev_val = val_reg[i];
        end
        else
        begin : g_mid
            assign ins_here = lt_reg[i-1];
            assign prev_key = key_reg[i-1];
            assign prev_val = val_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_key = key_reg[i];
            assign next_val = val_reg[i];
        end
        else
        begin : g_inner
            assign next_key = key_reg[i+1];
            assign next_val = val_reg[i+1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.commit)
            begin
                if (do_update && eq_reg[i])
                    val_reg[i] <= req_reg.store_value;
                else if (do_insert && !lt_reg[i])
                begin
                    key_reg[i] <= ins_here ? req_reg.lookup_key  : prev_key;
                    val_reg[i] <= ins_here ? req_reg.store_value : prev_val;
                end
                else if (do_remove && !lt_reg[i])
                begin
                    key_reg[i] <= next_key;
                    val_reg[i] <= next_val;
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (do_insert)
        begin
            valid_next = {valid_reg[CAPACITY-2:0], 1'b1};
            count_next = count_reg + COUNT_W'(1);
        end
        else if (do_remove)
        begin
            valid_next = {1'b0, valid_reg[CAPACITY-1:1]};
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rsp_reg.found       <= hit;
            rsp_reg.read_value  <= (is_get && hit) ? hit_value : NO_VALUE;
            rsp_reg.full_error  <= is_put && !hit && full;
            rsp_reg.entry_count <= sat_count(count_next);
        end
    end

    assign rsp = rsp_reg;

endmodule

/* rtl/sorted_key_value_map.sv */
// top level of the sorted key-value map
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   direction  handshake              beat
// req       in         req_valid / req_stall  action, lookup_key, store_value
// rsp       out        rsp_valid / rsp_stall  found, read_value, full_error, entry_count
//
// every request runs slot compare on accept, then row update and result
// a new request is taken while the previous result still waits in the output register
// a stalled result holds the next request in evaluation until the register frees up
// reset leaves the store empty; no clearing pass is needed

module sorted_key_value_map (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  skvm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output skvm_pkg::rsp_t rsp
);
    import skvm_pkg::*;

    dp_cmd_t cmd;

    skvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    skvm_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && !req_stall, req_stall)
    `ASSERT_IMPLY(a_miss_no_value, clk, rst_n, rsp_valid && !rsp.found, rsp.read_value == NO_VALUE)
    `ASSERT_IMPLY(a_full_not_found, clk, rst_n, rsp_valid && rsp.full_error, !rsp.found)
    `ASSERT_IMPLY(a_full_count, clk, rst_n, rsp_valid && rsp.full_error,
                  rsp.entry_count == sat_count(COUNT_W'(CAPACITY)))

endmodule

/* dv/sorted_key_value_map_test.sv */
// self-checking testbench for the sorted key-value map: directed and random put, get, remove traffic
`timescale 1ns / 1ps

module sorted_key_value_map_test;
    import skvm_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 35;
    localparam int DRAIN_CYCLES = 10;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic signed [KEY_W-1:0] map_keys [CAPACITY];
    logic signed [KEY_W-1:0] map_values [CAPACITY];
    int map_count = 0;
    rsp_t pending_rsp [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;

    sorted_key_value_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sorted_key_value_map test failed");
        $finish;
    end

    function automatic int lower_slot(logic signed [KEY_W-1:0] k);
        int i;
        i = 0;
        while (i < map_count && map_keys[i] < k)
            i++;
        return i;
    endfunction

    function automatic bit key_present(logic signed [KEY_W-1:0] k);
        int pos;
        pos = lower_slot(k);
        return pos < map_count && map_keys[pos] == k;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int pos;
        bit hit;
        pos = lower_slot(r.lookup_key);
        hit = pos < map_count && map_keys[pos] == r.lookup_key;
        res.found = hit;
        res.read_value = NO_VALUE;
        res.full_error = 1'b0;
        case (r.action)
            ACT_PUT:
            begin
                if (hit)
                    map_values[pos] = r.store_value;
                else if (map_count >= CAPACITY)
                    res.full_error = 1'b1;
                else
                begin
                    for (int i = map_count; i > pos; i--)
                    begin
                        map_keys[i] = map_keys[i - 1];
                        map_values[i] = map_values[i - 1];
                    end
                    map_keys[pos] = r.lookup_key;
                    map_values[pos] = r.store_value;
                    map_count++;
                end
            end
            ACT_GET:
            begin
                if (hit)
                    res.read_value = map_values[pos];
            end
            ACT_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = pos; i + 1 < map_count; i++)
                    begin
                        map_keys[i] = map_keys[i + 1];
                        map_values[i] = map_values[i + 1];
                    end
                    map_count--;
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = (map_count > int'(ENTRY_MAX)) ? ENTRY_MAX : ENTRY_W'(map_count);
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_response(rsp_t got);
        rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            report_mismatch($sformatf("result beat with nothing expected: %p", got));
            return;
        end
        want = pending_rsp.pop_front();
        if (got.found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
        if (got.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                got.read_value, want.read_value));
        if (got.full_error !== want.full_error)
            report_mismatch($sformatf("full_error %b, expected %b",
                got.full_error, want.full_error));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                got.entry_count, want.entry_count));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_response(rsp);
    end

    always @(posedge clk)
    begin
        rsp_stall <= stalls_on && ($urandom_range(99) < IDLE_PCT);
    end

    task automatic send_request(logic [1:0] act, logic signed [KEY_W-1:0] key,
                                logic signed [KEY_W-1:0] val);
        req_t beat;
        beat.action = act;
        beat.lookup_key = key;
        beat.store_value = val;
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp.push_back(apply_request(beat));
    endtask

    function automatic logic [1:0] pick_action(int put_pct);
        int r;
        r = $urandom_range(99);
        if (r < put_pct)
            return ACT_PUT;
        else if (r < put_pct + (95 - put_pct) / 2)
            return ACT_GET;
        else if (r < 95)
            return ACT_REMOVE;
        else
            return ACT_UNUSED;
    endfunction

    task automatic empty_store_test();
        send_request(ACT_GET, KEY_MIN, KEY_MAX);
        send_request(ACT_REMOVE, KEY_MAX, 0);
        send_request(ACT_UNUSED, 0, -1);
    endtask

    task automatic extremes_test();
        send_request(ACT_PUT, KEY_MIN, KEY_MAX);
        send_request(ACT_PUT, KEY_MAX, KEY_MIN);
        send_request(ACT_PUT, 0, 0);
        send_request(ACT_PUT, -1, -1);
        send_request(ACT_PUT, 1, 1);
        send_request(ACT_GET, KEY_MIN, 0);
        send_request(ACT_GET, KEY_MAX, -1);
        send_request(ACT_GET, -1, KEY_MAX);
        send_request(ACT_GET, 0, 0);
        send_request(ACT_PUT, KEY_MIN, 32'sh1234_5678);
        send_request(ACT_GET, KEY_MIN, 0);
        send_request(ACT_UNUSED, KEY_MAX, 32'sh5a5a_5a5a);
        send_request(ACT_UNUSED, 2, 0);
        send_request(ACT_REMOVE, 0, KEY_MAX);
        send_request(ACT_GET, 0, 0);
        send_request(ACT_REMOVE, 0, 0);
        send_request(ACT_REMOVE, KEY_MIN, 0);
        send_request(ACT_GET, KEY_MAX, 0);
    endtask

    task automatic random_traffic_test(int n, int pool_size, int put_pct);
        logic signed [KEY_W-1:0] key_pool [$];
        logic signed [KEY_W-1:0] key;
        key_pool = '{KEY_MIN, KEY_MAX, 0, -1};
        while (key_pool.size() < pool_size)
            key_pool.push_back($urandom);
        repeat (n)
        begin
            if ($urandom_range(99) < 90)
                key = key_pool[$urandom_range(key_pool.size() - 1)];
            else
                key = $urandom;
            send_request(pick_action(put_pct), key, $urandom);
        end
    endtask

    task automatic back_to_back_test(int n);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        random_traffic_test(n, 24, 45);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic full_store_test();
        logic signed [KEY_W-1:0] key;
        while (map_count < CAPACITY)
        begin
            key = $urandom;
            while (key_present(key))
                key = $urandom;
            send_request(ACT_PUT, key, $urandom);
        end
        key = $urandom;
        while (key_present(key))
            key = $urandom;
        // refused insert, then update and lookup of a stored key
        send_request(ACT_PUT, key, $urandom);
        send_request(ACT_PUT, map_keys[$urandom_range(CAPACITY - 1)], $urandom);
        send_request(ACT_GET, map_keys[$urandom_range(CAPACITY - 1)], 0);
        send_request(ACT_UNUSED, key, $urandom);
        send_request(ACT_REMOVE, map_keys[$urandom_range(CAPACITY - 1)], 0);
        send_request(ACT_PUT, key, $urandom);
        send_request(ACT_PUT, ~key, $urandom);
        while (map_count > 0)
        begin
            if ($urandom_range(3) == 0)
                send_request(ACT_GET, map_keys[$urandom_range(map_count - 1)], $urandom);
            send_request(ACT_REMOVE, map_keys[$urandom_range(map_count - 1)], $urandom);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        empty_store_test();
        extremes_test();
        random_traffic_test(250, 16, 45);
        back_to_back_test(100);
        full_store_test();
        random_traffic_test(250, 100, 60);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("sorted_key_value_map test passed");
        else
            $display("sorted_key_value_map test failed");
        $finish;
    end

endmodule
